[rtl/gbf_pkg.sv]
// ----------------------------------------------------------------------------
// gbf_pkg
// Shared types and constants for the two-fix bearing pipeline.
// ----------------------------------------------------------------------------
package gbf_pkg;

  typedef logic signed [33:0] ang_t;   // angle, 2^-24 degree
  typedef logic signed [33:0] cosv_t;  // cosine datapath, 2^30 scale
  typedef logic signed [44:0] vec_t;   // vectoring datapath
  typedef logic signed [60:0] dxy_t;   // scaled dx / dy

  localparam ang_t DEG90 = 34'sd1509949440;
  localparam ang_t DEG180 = 34'sd3019898880;
  localparam cosv_t INV_GAIN = 34'sd652032874;
  localparam logic [24:0] FULL_TURN = 25'd23592960;
  // floor(2^56 / 10^7): degree conversion by reciprocal multiply.
  localparam logic [32:0] RECIP_K = 33'd7205759403;
  localparam logic [54:0] TEN7 = 55'd10000000;
  localparam logic [54:0] TWO_TEN7 = 55'd20000000;
  localparam logic [54:0] HALF_TEN7 = 55'd5000000;
  localparam int NORM_BITS = 41;

  localparam ang_t ATAN_TAB [32] = '{
    34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
    34'sd60000934, 34'sd30029717, 34'sd15018523, 34'sd7509720,
    34'sd3754917, 34'sd1877466, 34'sd938734, 34'sd469367,
    34'sd234684, 34'sd117342, 34'sd58671, 34'sd29335,
    34'sd14668, 34'sd7334, 34'sd3667, 34'sd1833,
    34'sd917, 34'sd458, 34'sd229, 34'sd115,
    34'sd57, 34'sd29, 34'sd14, 34'sd7,
    34'sd4, 34'sd2, 34'sd1, 34'sd0
  };

endpackage

[rtl/gps_bearing_from_two_fixes_core.sv]
// ----------------------------------------------------------------------------
// gps_bearing_from_two_fixes_core
// Compass bearing from two GPS fixes by an equirectangular approximation.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the four fix coordinates (1e-7 degree, signed) on the in_ ports and
//   pulse start. A transaction is taken at every clock edge where start is
//   high and busy is low; busy is low whenever the block is out of reset, so
//   a new pair of fixes can enter every cycle.
//   Each result appears on out_bearing (1/65536 degree, in (0,360]) with
//   out_valid high for exactly one cycle. The pipeline is made of two
//   unrolled CORDIC chains (one for cos(lat1), one for atan2) of one stage
//   per micro-rotation, plus the degree conversion, multiply, normalize and
//   output stages.
//   Throughput is one result per cycle; results come out in input order.
//   The receiver cannot stall, so nothing is held back.
//   Reset clears the valid chain: transactions in flight are dropped, and
//   busy stays high while reset is asserted.
// ----------------------------------------------------------------------------
module gps_bearing_from_two_fixes_core #(
  parameter int CORDIC_ITERATIONS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] in_start_latitude,
  input  logic signed [31:0] in_start_longitude,
  input  logic signed [30:0] in_target_latitude,
  input  logic signed [31:0] in_target_longitude,
  output logic               out_valid,
  output logic        [24:0] out_bearing
);

  localparam int N = CORDIC_ITERATIONS;
  localparam int LAT = 2 * N + 13;

  logic [LAT-1:0] vld_r;
  logic           accept;

  assign busy = !rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // Stage 1: differences and |lat1|.
  logic signed [31:0] s1_dlat_r;
  logic signed [32:0] s1_dlon_r;
  logic        [30:0] s1_a_r;

  always_ff @(posedge clk) begin
    s1_dlat_r <= 32'(in_target_latitude) - 32'(in_start_latitude);
    s1_dlon_r <= 33'(in_target_longitude) - 33'(in_start_longitude);
    s1_a_r <= in_start_latitude[30] ? 31'(-in_start_latitude) : 31'(in_start_latitude);
  end

  // Stage 2: partial products of |lat1| times the reciprocal.
  logic signed [31:0] s2_dlat_r;
  logic signed [32:0] s2_dlon_r;
  logic        [30:0] s2_a_r;
  logic        [47:0] s2_phi_r;
  logic        [46:0] s2_plo_r;

  always_ff @(posedge clk) begin
    s2_dlat_r <= s1_dlat_r;
    s2_dlon_r <= s1_dlon_r;
    s2_a_r <= s1_a_r;
    s2_phi_r <= 48'(s1_a_r) * 48'(gbf_pkg::RECIP_K[32:16]);
    s2_plo_r <= 47'(s1_a_r) * 47'(gbf_pkg::RECIP_K[15:0]);
  end

  // Stage 3: quotient estimate, at most two below the rounded quotient.
  logic signed [31:0] s3_dlat_r;
  logic signed [32:0] s3_dlon_r;
  logic        [30:0] s3_a_r;
  logic        [30:0] s3_e_r;
  logic        [63:0] s3_sum;

  assign s3_sum = {s2_phi_r, 16'd0} + 64'(s2_plo_r);

  always_ff @(posedge clk) begin
    s3_dlat_r <= s2_dlat_r;
    s3_dlon_r <= s2_dlon_r;
    s3_a_r <= s2_a_r;
    s3_e_r <= s3_sum[62:32];
  end

  // Stage 4: numerator and estimate times the divisor.
  logic signed [31:0] s4_dlat_r;
  logic signed [32:0] s4_dlon_r;
  logic        [30:0] s4_e_r;
  logic        [54:0] s4_num_r;
  logic        [54:0] s4_prod_r;

  always_ff @(posedge clk) begin
    s4_dlat_r <= s3_dlat_r;
    s4_dlon_r <= s3_dlon_r;
    s4_e_r <= s3_e_r;
    s4_num_r <= {s3_a_r, 24'd0} + gbf_pkg::HALF_TEN7;
    s4_prod_r <= 55'(s3_e_r) * gbf_pkg::TEN7;
  end

  // Stage 5: remainder correction gives the latitude in 2^-24 degree.
  logic signed [31:0] s5_dlat_r;
  logic signed [32:0] s5_dlon_r;
  logic        [30:0] s5_t_r;
  logic        [54:0] s5_rem;

  assign s5_rem = s4_num_r - s4_prod_r;

  always_ff @(posedge clk) begin
    s5_dlat_r <= s4_dlat_r;
    s5_dlon_r <= s4_dlon_r;
    s5_t_r <= s4_e_r + 31'(s5_rem >= gbf_pkg::TEN7) + 31'(s5_rem >= gbf_pkg::TWO_TEN7);
  end

  // Stage 6 and cosine CORDIC chain. Index 0 is the folded start angle.
  gbf_pkg::cosv_t     cx_r [0:N];
  gbf_pkg::cosv_t     cy_r [0:N];
  gbf_pkg::ang_t      cz_r [0:N];
  logic               cneg_r [0:N];
  logic signed [31:0] cdlat_r [0:N];
  logic signed [32:0] cdlon_r [0:N];

  always_ff @(posedge clk) begin
    // A latitude beyond the pole folds back and flips the cosine sign.
    if (34'(s5_t_r) > gbf_pkg::DEG90) begin
      cz_r[0] <= gbf_pkg::DEG180 - gbf_pkg::ang_t'({3'b000, s5_t_r});
      cneg_r[0] <= 1'b1;
    end else begin
      cz_r[0] <= gbf_pkg::ang_t'({3'b000, s5_t_r});
      cneg_r[0] <= 1'b0;
    end
    cx_r[0] <= gbf_pkg::INV_GAIN;
    cy_r[0] <= '0;
    cdlat_r[0] <= s5_dlat_r;
    cdlon_r[0] <= s5_dlon_r;
  end

  for (genvar i = 0; i < N; i++) begin : g_cos
    always_ff @(posedge clk) begin
      if (!cz_r[i][33]) begin
        cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] - gbf_pkg::ATAN_TAB[i];
      end else begin
        cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] + gbf_pkg::ATAN_TAB[i];
      end
      cneg_r[i+1] <= cneg_r[i];
      cdlat_r[i+1] <= cdlat_r[i];
      cdlon_r[i+1] <= cdlon_r[i];
    end
  end

  // Cosine rounded to 2^26 scale.
  logic signed [29:0] k_c_r;
  logic signed [31:0] k_dlat_r;
  logic signed [32:0] k_dlon_r;
  gbf_pkg::cosv_t     k_xf;
  gbf_pkg::cosv_t     k_xr;

  assign k_xf = cneg_r[N] ? -cx_r[N] : cx_r[N];
  assign k_xr = (k_xf + 34'sd8) >>> 4;

  always_ff @(posedge clk) begin
    k_c_r <= k_xr[29:0];
    k_dlat_r <= cdlat_r[N];
    k_dlon_r <= cdlon_r[N];
  end

  // cos times the longitude difference, as two partial products.
  logic signed [46:0] m_phi_r;
  logic signed [46:0] m_plo_r;
  logic signed [31:0] m_dlat_r;

  always_ff @(posedge clk) begin
    m_phi_r <= 47'(k_c_r) * 47'($signed(k_dlon_r[32:16]));
    m_plo_r <= 47'(k_c_r) * 47'($signed({1'b0, k_dlon_r[15:0]}));
    m_dlat_r <= k_dlat_r;
  end

  gbf_pkg::dxy_t d_dx_r;
  gbf_pkg::dxy_t d_dy_r;

  always_ff @(posedge clk) begin
    d_dx_r <= (61'(m_phi_r) <<< 16) + 61'(m_plo_r);
    d_dy_r <= 61'(m_dlat_r) <<< 26;
  end

  // Larger magnitude of the two components.
  gbf_pkg::dxy_t a_dx_r;
  gbf_pkg::dxy_t a_dy_r;
  logic [60:0]   a_m_r;
  logic [60:0]   a_ax;
  logic [60:0]   a_ay;

  assign a_ax = d_dx_r[60] ? 61'(-d_dx_r) : 61'(d_dx_r);
  assign a_ay = d_dy_r[60] ? 61'(-d_dy_r) : 61'(d_dy_r);

  always_ff @(posedge clk) begin
    a_dx_r <= d_dx_r;
    a_dy_r <= d_dy_r;
    a_m_r <= (a_ax > a_ay) ? a_ax : a_ay;
  end

  // Shift that brings the larger magnitude below 2^41.
  gbf_pkg::dxy_t n_dx_r;
  gbf_pkg::dxy_t n_dy_r;
  logic [4:0]    n_sh_r;
  logic [4:0]    n_sh;

  always_comb begin
    n_sh = '0;
    for (int k = gbf_pkg::NORM_BITS; k < 61; k++) begin
      if (a_m_r[k]) begin
        n_sh = 5'(k - gbf_pkg::NORM_BITS + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    n_dx_r <= a_dx_r;
    n_dy_r <= a_dy_r;
    n_sh_r <= n_sh;
  end

  // Normalize, then pre-rotate into the right half plane; vectoring chain.
  gbf_pkg::vec_t vx_r [0:N];
  gbf_pkg::vec_t vy_r [0:N];
  gbf_pkg::ang_t vz_r [0:N];
  logic          vzero_r [0:N];
  gbf_pkg::dxy_t v_xs;
  gbf_pkg::dxy_t v_ys;
  gbf_pkg::vec_t v_x;
  gbf_pkg::vec_t v_y;

  assign v_xs = n_dx_r >>> n_sh_r;
  assign v_ys = n_dy_r >>> n_sh_r;
  assign v_x = 45'(v_xs);
  assign v_y = 45'(v_ys);

  always_ff @(posedge clk) begin
    if (v_x[44] && !v_y[44]) begin
      vx_r[0] <= v_y;
      vy_r[0] <= -v_x;
      vz_r[0] <= gbf_pkg::DEG90;
    end else if (v_x[44]) begin
      vx_r[0] <= -v_y;
      vy_r[0] <= v_x;
      vz_r[0] <= -gbf_pkg::DEG90;
    end else begin
      vx_r[0] <= v_x;
      vy_r[0] <= v_y;
      vz_r[0] <= '0;
    end
    vzero_r[0] <= (v_x == '0) && (v_y == '0);
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (!vy_r[i][44]) begin
        vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
        vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
        vz_r[i+1] <= vz_r[i] + gbf_pkg::ATAN_TAB[i];
      end else begin
        vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
        vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
        vz_r[i+1] <= vz_r[i] - gbf_pkg::ATAN_TAB[i];
      end
      vzero_r[i+1] <= vzero_r[i];
    end
  end

  // Bearing = 90 - angle, rounded to 1/65536 degree and wrapped into (0,360].
  gbf_pkg::ang_t      o_ang;
  logic signed [35:0] o_rr;
  logic signed [35:0] o_full;
  logic        [24:0] o_bearing;
  logic        [24:0] out_bearing_r;

  assign o_ang = vzero_r[N] ? '0 : vz_r[N];
  assign o_rr = (36'(gbf_pkg::DEG90) - 36'(o_ang) + 36'sd128) >>> 8;
  assign o_full = 36'(gbf_pkg::FULL_TURN);

  always_comb begin
    if (o_rr <= 36'sd0) begin
      o_bearing = 25'(o_rr + o_full);
    end else if (o_rr > o_full) begin
      o_bearing = 25'(o_rr - o_full);
    end else begin
      o_bearing = 25'(o_rr);
    end
  end

  always_ff @(posedge clk) begin
    out_bearing_r <= o_bearing;
  end

  assign out_valid = vld_r[LAT-1];
  assign out_bearing = out_bearing_r;

  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bearing != 25'd0) && (out_bearing <= gbf_pkg::FULL_TURN))
    else $error("bearing outside (0,360]");

  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_prerot_half: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[N+11] |-> !vx_r[0][44])
    else $error("pre-rotation left x negative");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the two-fix bearing pipeline against a bit-exact software predictor
// of its CORDIC arithmetic: directed extremes and corner cases, then random
// pairs of fixes with random gaps on the command side.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ITERS = 20;
  localparam int LATENCY = 2 * ITERS + 13;
  localparam longint LAT_LIM = 900000000;
  localparam longint LON_LIM = 1800000000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [30:0] in_start_latitude;
  logic signed [31:0] in_start_longitude;
  logic signed [30:0] in_target_latitude;
  logic signed [31:0] in_target_longitude;
  logic               out_valid;
  logic        [24:0] out_bearing;

  logic [24:0] bearing_queue[$];
  int          error_count;

  gps_bearing_from_two_fixes_core #(.CORDIC_ITERATIONS(ITERS)) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_start_latitude   (in_start_latitude),
    .in_start_longitude  (in_start_longitude),
    .in_target_latitude  (in_target_latitude),
    .in_target_longitude (in_target_longitude),
    .out_valid           (out_valid),
    .out_bearing         (out_bearing)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cos(lat) at 2^30 scale; latitudes past a pole fold back with a sign flip.
  function automatic longint cos_of_lat(longint lat);
    longint a, t, x, y, z, xs, ys, step;
    bit     flip;
    a = (lat < 0) ? -lat : lat;
    t = (a * 64'sd16777216 + 64'sd5000000) / 64'sd10000000;
    flip = 1'b0;
    if (t > longint'(gbf_pkg::DEG90)) begin
      t = longint'(gbf_pkg::DEG180) - t;
      flip = 1'b1;
    end
    x = longint'(gbf_pkg::INV_GAIN);
    y = 0;
    z = t;
    for (int i = 0; i < ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      step = longint'(gbf_pkg::ATAN_TAB[i]);
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - step;
      end else begin
        x = x + ys; y = y - xs; z = z + step;
      end
    end
    return flip ? -x : x;
  endfunction

  function automatic longint atan2_of(longint yin, longint xin);
    longint x, y, z, t, xs, ys, step;
    x = xin;
    y = yin;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = longint'(gbf_pkg::DEG90);
      end else begin
        x = -y; y = t; z = -longint'(gbf_pkg::DEG90);
      end
    end
    for (int i = 0; i < ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      step = longint'(gbf_pkg::ATAN_TAB[i]);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + step;
      end else begin
        x = x - ys; y = y + xs; z = z - step;
      end
    end
    return z;
  endfunction

  function automatic logic [24:0] bearing_of(longint lat1, longint lon1, longint lat2,
                                             longint lon2);
    longint c, dxf, dyf, ax, ay, m, r;
    int     sh;
    c = (cos_of_lat(lat1) + 8) >>> 4;
    dxf = c * (lon2 - lon1);
    dyf = (lat2 - lat1) * (64'sd1 <<< 26);
    ax = (dxf < 0) ? -dxf : dxf;
    ay = (dyf < 0) ? -dyf : dyf;
    m = (ax > ay) ? ax : ay;
    sh = 0;
    while (m >= (64'sd1 <<< gbf_pkg::NORM_BITS)) begin
      m = m >>> 1;
      sh++;
    end
    r = (longint'(gbf_pkg::DEG90) - atan2_of(dyf >>> sh, dxf >>> sh) + 128) >>> 8;
    while (r <= 0) r = r + longint'(gbf_pkg::FULL_TURN);
    while (r > longint'(gbf_pkg::FULL_TURN)) r = r - longint'(gbf_pkg::FULL_TURN);
    return r[24:0];
  endfunction

  // Accepted transactions are predicted and results checked on the same edge.
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      bearing_queue.push_back(bearing_of(in_start_latitude, in_start_longitude,
                                         in_target_latitude, in_target_longitude));
    if (rst_n && out_valid) begin
      if (bearing_queue.size() == 0) begin
        $error("unexpected result: bearing %0d", out_bearing);
        error_count++;
      end else begin
        logic [24:0] want;
        want = bearing_queue.pop_front();
        if (out_bearing !== want) begin
          $error("bearing mismatch: expected %0d actual %0d", want, out_bearing);
          error_count++;
        end
      end
    end
  end

  task automatic idle_gap();
    int roll, len;
    roll = $urandom_range(0, 99);
    if (roll < 55) len = 0;
    else if (roll < 92) len = $urandom_range(1, 4);
    else len = $urandom_range(10, 80);
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic send_fixes(longint lat1, longint lon1, longint lat2, longint lon2,
                            bit gaps);
    if (gaps) idle_gap();
    start <= 1'b1;
    in_start_latitude <= lat1[30:0];
    in_start_longitude <= lon1[31:0];
    in_target_latitude <= lat2[30:0];
    in_target_longitude <= lon2[31:0];
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (bearing_queue.size() != 0) @(posedge clk);
  endtask

  function automatic longint rand_span(longint lim);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task automatic test_extremes();
    longint lat_max, lat_min, lon_max, lon_min;
    lat_max = 64'sd1073741823;
    lat_min = -64'sd1073741824;
    lon_max = 64'sd2147483647;
    lon_min = -64'sd2147483648;
    send_fixes(lat_min, lon_min, lat_max, lon_max, 1'b0);
    send_fixes(lat_max, lon_max, lat_min, lon_min, 1'b0);
    send_fixes(lat_max, lon_min, lat_max, lon_max, 1'b0);
    send_fixes(lat_min, lon_max, lat_min, lon_min, 1'b0);
    send_fixes(-LAT_LIM, -LON_LIM, LAT_LIM, LON_LIM, 1'b0);
    send_fixes(LAT_LIM, LON_LIM, -LAT_LIM, -LON_LIM, 1'b0);
    send_fixes(0, 0, 0, lon_max, 1'b0);
    send_fixes(0, 0, lat_min, 0, 1'b0);
  endtask

  task automatic test_special_cases();
    // Coincident fixes, and a pure longitude step at a pole.
    send_fixes(0, 0, 0, 0, 1'b0);
    send_fixes(123456789, -55555555, 123456789, -55555555, 1'b0);
    send_fixes(LAT_LIM, 0, LAT_LIM, 1000, 1'b0);
    // Start latitude past a pole turns cosine negative.
    send_fixes(1000000000, 0, 1000000000, 10000000, 1'b0);
    send_fixes(-1050000000, 5, -1049000000, -700000, 1'b0);
    // Across the antimeridian without wrapping.
    send_fixes(100000, 1799999999, 100000, -1799999999, 1'b0);
    send_fixes(100000, -1799999999, 100100, 1799999999, 1'b0);
    // Due north, due south, due east, due west.
    send_fixes(0, 0, 1, 0, 1'b0);
    send_fixes(0, 0, -1, 0, 1'b0);
    send_fixes(0, 0, 0, 1, 1'b0);
    send_fixes(0, 0, 0, -1, 1'b0);
    send_fixes(500000000, 20000000, 500000001, 20000000, 1'b0);
    send_fixes(-300000000, 1, -300000000 + 10000000, 0, 1'b0);
  endtask

  task automatic test_drain_mid_run();
    for (int i = 0; i < 20; i++)
      send_fixes(rand_span(LAT_LIM), rand_span(LON_LIM), rand_span(LAT_LIM),
                 rand_span(LON_LIM), 1'b1);
    wait_for_results();
  endtask

  task automatic test_random(int count);
    longint lat1, lon1, lat2, lon2;
    int     kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        // Raw field bits, including latitudes past the poles.
        lat1 = longint'($signed($urandom() & 32'h7fff_ffff) <<< 1) >>> 1;
        lat2 = longint'($signed($urandom() & 32'h7fff_ffff) <<< 1) >>> 1;
        lon1 = longint'($signed($urandom()));
        lon2 = longint'($signed($urandom()));
      end else if (kind < 6) begin
        lat1 = rand_span(LAT_LIM);
        lon1 = rand_span(LON_LIM);
        lat2 = rand_span(LAT_LIM);
        lon2 = rand_span(LON_LIM);
      end else begin
        // Nearby fixes, the ordinary navigation case.
        lat1 = rand_span(LAT_LIM - 100000);
        lon1 = rand_span(LON_LIM - 100000);
        lat2 = lat1 + longint'($urandom_range(0, 200000)) - 100000;
        lon2 = lon1 + longint'($urandom_range(0, 200000)) - 100000;
        if (kind == 9) lat2 = lat1;
      end
      send_fixes(lat1, lon1, lat2, lon2, (i % 150) > 40);
    end
  endtask

  initial begin
    error_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_start_latitude = '0;
    in_start_longitude = '0;
    in_target_latitude = '0;
    in_target_longitude = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_special_cases();
    test_drain_mid_run();
    test_random(900);
    wait_for_results();
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
